### rtl/assert_macros.svh
// ------------------------------------------------------------------------
// assert_macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while reset is high.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// when cond holds, prop must hold in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// when cond holds, prop must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

### rtl/bat_pct_pkg.sv
// ------------------------------------------------------------------------
// bat_pct_pkg
// Widths, constants, controller states and the discharge curve table
// for the battery average to percent block.
// ------------------------------------------------------------------------
package bat_pct_pkg;

   localparam int HISTORY_DEPTH_DEF = 5;
   localparam int CURVE_POINTS_DEF  = 21;

   localparam int SAMPLE_W    = 11;
   localparam int AVG_W       = 10;
   localparam int MV_W        = 16;
   localparam int PCT_W       = 7;
   localparam int CFG_W       = 12;
   localparam int CSR_IDX_W   = 1;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;

   // shared divider: dividend up to 12x10 product, divisor 12 bits
   localparam int DIV_W = 22;
   localparam int REM_W = 12;
   localparam int CNT_W = 5;

   localparam int PROD_W = 26;
   localparam int MVX_W  = 19;
   localparam int FRAC_W = 19;
   localparam int BASE_W = 8;

   localparam int CURVE_IDX_W = 5;

   localparam logic [CFG_W-1:0]  NUM_RESET    = 12'd2050;
   localparam logic [CFG_W-1:0]  DEN_RESET    = 12'd1000;
   localparam logic [PROD_W-1:0] REF_MV       = 26'd600;
   localparam logic [MVX_W-1:0]  PRESCALE     = 19'd6;
   localparam logic [BASE_W-1:0] STEP_PERCENT = 8'd5;
   localparam logic [BASE_W-1:0] FULL_PERCENT = 8'd100;
   localparam logic [MV_W-1:0]   MV_SAT       = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] REG_NUMERATOR   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DENOMINATOR = 1'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_AVG_DIV,
      ST_MUL,
      ST_SCALE_DIV,
      ST_MV_A,
      ST_MV_B,
      ST_SEARCH,
      ST_FRAC,
      ST_OUT
   } state_type;

   // lipo discharge curve in millivolts, 5 percent per point
   function automatic logic [MV_W-1:0] curve_mv(input logic [CURVE_IDX_W-1:0] idx);
      logic [MV_W-1:0] v;
      case (idx)
         5'd0:    v = 16'd3270;
         5'd1:    v = 16'd3610;
         5'd2:    v = 16'd3690;
         5'd3:    v = 16'd3710;
         5'd4:    v = 16'd3730;
         5'd5:    v = 16'd3750;
         5'd6:    v = 16'd3770;
         5'd7:    v = 16'd3790;
         5'd8:    v = 16'd3800;
         5'd9:    v = 16'd3820;
         5'd10:   v = 16'd3840;
         5'd11:   v = 16'd3850;
         5'd12:   v = 16'd3870;
         5'd13:   v = 16'd3910;
         5'd14:   v = 16'd3950;
         5'd15:   v = 16'd3980;
         5'd16:   v = 16'd4020;
         5'd17:   v = 16'd4080;
         5'd18:   v = 16'd4110;
         5'd19:   v = 16'd4150;
         5'd20:   v = 16'd4200;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/battery_average_to_percent.sv
// ------------------------------------------------------------------------
// battery_average_to_percent
// Flow: the history sum, the mean on the bit-serial divider (22 steps,
// used twice), the product on the shift-add multiplier (10 steps), the
// ratio divide, the millivolt scaling, the curve search and, when
// interpolating, the fraction steps. Throughput: one item at a time; the
// next beat is taken once the result is loaded, which waits on the result side.
// Reset: synchronous; clears history, write slot, control state, ratio and response valid.
// ------------------------------------------------------------------------
module battery_average_to_percent #(
   parameter int HISTORY_DEPTH = bat_pct_pkg::HISTORY_DEPTH_DEF,
   parameter int CURVE_POINTS  = bat_pct_pkg::CURVE_POINTS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // tdata: adc_sample[10:0]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bat_pct_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tdata: average_code[9:0], battery_millivolts[25:10], charge_percent[32:26]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bat_pct_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                                  csr_we,
   input  logic [bat_pct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bat_pct_pkg::CFG_W-1:0]         csr_wdata
);

`include "assert_macros.svh"

   localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SUM_W  = bat_pct_pkg::AVG_W + SLOT_W;
   localparam int PT_W   = $clog2(CURVE_POINTS);

   localparam int DIV_W  = bat_pct_pkg::DIV_W;
   localparam int REM_W  = bat_pct_pkg::REM_W;
   localparam int CNT_W  = bat_pct_pkg::CNT_W;
   localparam int AVG_W  = bat_pct_pkg::AVG_W;
   localparam int MV_W   = bat_pct_pkg::MV_W;
   localparam int PCT_W  = bat_pct_pkg::PCT_W;
   localparam int CFG_W  = bat_pct_pkg::CFG_W;
   localparam int PROD_W = bat_pct_pkg::PROD_W;
   localparam int MVX_W  = bat_pct_pkg::MVX_W;
   localparam int FRAC_W = bat_pct_pkg::FRAC_W;
   localparam int BASE_W = bat_pct_pkg::BASE_W;
   localparam int CIW    = bat_pct_pkg::CURVE_IDX_W;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);
   localparam logic [PCT_W-1:0]  PCT_FULL  = PCT_W'(bat_pct_pkg::FULL_PERCENT);

   bat_pct_pkg::state_type state_ff, state_in;

   logic [AVG_W-1:0]  hist_ff [HISTORY_DEPTH];
   logic [AVG_W-1:0]  hist_in [HISTORY_DEPTH];
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CFG_W-1:0]  num_ff, num_in;
   logic [CFG_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [DIV_W-1:0]  div_q_ff, div_q_in;
   logic [REM_W-1:0]  div_r_ff, div_r_in;
   logic [CFG_W-1:0]  div_d_ff, div_d_in;

   logic [DIV_W-1:0]  mul_acc_ff, mul_acc_in;
   logic [DIV_W-1:0]  mul_a_ff, mul_a_in;
   logic [AVG_W-1:0]  mul_b_ff, mul_b_in;

   logic [AVG_W-1:0]  avg_ff, avg_in;
   logic [MV_W-1:0]   scaled_ff, scaled_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [MV_W-1:0]   mv_ff, mv_in;
   logic [PT_W-1:0]   pt_ff, pt_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [FRAC_W-1:0] fr_rem_ff, fr_rem_in;
   logic [MV_W-1:0]   span_ff, span_in;
   logic [2:0]        fr_q_ff, fr_q_in;
   logic [PCT_W-1:0]  pct_ff, pct_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0]  rsp_avg_ff, rsp_avg_in;
   logic [MV_W-1:0]   rsp_mv_ff, rsp_mv_in;
   logic [PCT_W-1:0]  rsp_pct_ff, rsp_pct_in;

   // one restoring divider step, shared by the mean and the ratio scaling
   logic [REM_W:0]    div_trial;
   logic              div_ge;
   logic [REM_W-1:0]  div_r_step;
   logic [DIV_W-1:0]  div_q_step;

   assign div_trial  = {div_r_ff, div_q_ff[DIV_W-1]};
   assign div_ge     = div_trial >= {1'b0, div_d_ff};
   assign div_r_step = div_ge ? REM_W'(div_trial - {1'b0, div_d_ff}) : div_trial[REM_W-1:0];
   assign div_q_step = {div_q_ff[DIV_W-2:0], div_ge};

   logic [MV_W-1:0]   cv_hi, cv_lo;
   assign cv_hi = bat_pct_pkg::curve_mv(CIW'(pt_ff));
   assign cv_lo = bat_pct_pkg::curve_mv(CIW'(PT_W'(pt_ff - 1'b1)));

   logic              in_search, in_sum;
   assign in_search = (state_ff == bat_pct_pkg::ST_SEARCH);
   assign in_sum    = (state_ff == bat_pct_pkg::ST_SUM);

   assign req_tready = (state_ff == bat_pct_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bat_pct_pkg::RSP_TDATA_W - AVG_W - MV_W - PCT_W){1'b0}},
                        rsp_pct_ff, rsp_mv_ff, rsp_avg_ff};

   always_comb begin
      logic [SUM_W-1:0]  sum_next;
      logic [DIV_W-1:0]  acc_next;
      logic [MVX_W-1:0]  mvx;
      logic [MV_W-1:0]   diff;
      logic [FRAC_W-1:0] shifted;
      logic              fr_ge;
      logic [2:0]        q_next;
      logic [BASE_W-1:0] pct_wide;

      state_in   = state_ff;
      hist_in    = hist_ff;
      slot_in    = slot_ff;
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      cnt_in     = cnt_ff;
      div_q_in   = div_q_ff;
      div_r_in   = div_r_ff;
      div_d_in   = div_d_ff;
      mul_acc_in = mul_acc_ff;
      mul_a_in   = mul_a_ff;
      mul_b_in   = mul_b_ff;
      avg_in     = avg_ff;
      scaled_in  = scaled_ff;
      prod_in    = prod_ff;
      mv_in      = mv_ff;
      pt_in      = pt_ff;
      base_in    = base_ff;
      fr_rem_in  = fr_rem_ff;
      span_in    = span_ff;
      fr_q_in    = fr_q_ff;
      pct_in     = pct_ff;
      rsp_avg_in = rsp_avg_ff;
      rsp_mv_in  = rsp_mv_ff;
      rsp_pct_in = rsp_pct_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      sum_next = sum_ff + SUM_W'(hist_ff[idx_ff]);
      acc_next = mul_acc_ff + (mul_b_ff[0] ? mul_a_ff : '0);
      mvx      = MVX_W'(prod_ff[PROD_W-1:10]) * bat_pct_pkg::PRESCALE;
      diff     = mv_ff - cv_lo;
      shifted  = FRAC_W'(span_ff) << cnt_ff[1:0];
      fr_ge    = fr_rem_ff >= shifted;
      q_next   = {fr_q_ff[1:0], fr_ge};
      pct_wide = base_ff + BASE_W'(q_next);

      if (csr_we) begin
         case (csr_index)
            bat_pct_pkg::REG_NUMERATOR:   num_in = csr_wdata;
            bat_pct_pkg::REG_DENOMINATOR: den_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         bat_pct_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               // negative samples are stored as zero
               hist_in[slot_ff] = req_tdata[bat_pct_pkg::SAMPLE_W-1] ? '0
                                                                    : req_tdata[AVG_W-1:0];
               slot_in  = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               idx_in   = '0;
               sum_in   = '0;
               state_in = bat_pct_pkg::ST_SUM;
            end
         end
         bat_pct_pkg::ST_SUM: begin
            sum_in = sum_next;
            if (idx_ff == SLOT_W'(HISTORY_DEPTH - 1)) begin
               div_q_in = DIV_W'(sum_next);
               div_r_in = '0;
               div_d_in = CFG_W'(HISTORY_DEPTH);
               cnt_in   = CNT_W'(DIV_W - 1);
               state_in = bat_pct_pkg::ST_AVG_DIV;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         bat_pct_pkg::ST_AVG_DIV: begin
            div_q_in = div_q_step;
            div_r_in = div_r_step;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               avg_in     = div_q_step[AVG_W-1:0];
               mul_acc_in = '0;
               mul_a_in   = DIV_W'(num_ff);
               mul_b_in   = div_q_step[AVG_W-1:0];
               cnt_in     = CNT_W'(AVG_W - 1);
               state_in   = bat_pct_pkg::ST_MUL;
            end
         end
         bat_pct_pkg::ST_MUL: begin
            mul_acc_in = acc_next;
            mul_a_in   = mul_a_ff << 1;
            mul_b_in   = mul_b_ff >> 1;
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               div_q_in = acc_next;
               div_r_in = '0;
               div_d_in = den_ff;
               cnt_in   = CNT_W'(DIV_W - 1);
               state_in = bat_pct_pkg::ST_SCALE_DIV;
            end
         end
         bat_pct_pkg::ST_SCALE_DIV: begin
            div_q_in = div_q_step;
            div_r_in = div_r_step;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               // zero denominator or quotient above 16 bits saturates
               if (den_ff == '0 || (|div_q_step[DIV_W-1:MV_W])) begin
                  scaled_in = bat_pct_pkg::MV_SAT;
               end else begin
                  scaled_in = div_q_step[MV_W-1:0];
               end
               state_in = bat_pct_pkg::ST_MV_A;
            end
         end
         bat_pct_pkg::ST_MV_A: begin
            prod_in  = PROD_W'(scaled_ff) * bat_pct_pkg::REF_MV;
            state_in = bat_pct_pkg::ST_MV_B;
         end
         bat_pct_pkg::ST_MV_B: begin
            mv_in    = (|mvx[MVX_W-1:MV_W]) ? bat_pct_pkg::MV_SAT : mvx[MV_W-1:0];
            pt_in    = '0;
            base_in  = '0;
            state_in = bat_pct_pkg::ST_SEARCH;
         end
         bat_pct_pkg::ST_SEARCH: begin
            if (pt_ff == '0) begin
               // at or below the first point reads as empty
               if (mv_ff <= cv_hi) begin
                  pct_in   = '0;
                  state_in = bat_pct_pkg::ST_OUT;
               end else begin
                  pt_in = PT_W'(1);
               end
            end else if (cv_hi >= mv_ff) begin
               fr_rem_in = FRAC_W'(diff) + (FRAC_W'(diff) << 2);
               span_in   = cv_hi - cv_lo;
               fr_q_in   = '0;
               cnt_in    = CNT_W'(2);
               state_in  = bat_pct_pkg::ST_FRAC;
            end else if (pt_ff == PT_W'(CURVE_POINTS - 1)) begin
               pct_in   = PCT_W'(bat_pct_pkg::FULL_PERCENT);
               state_in = bat_pct_pkg::ST_OUT;
            end else begin
               pt_in   = pt_ff + 1'b1;
               base_in = base_ff + bat_pct_pkg::STEP_PERCENT;
            end
         end
         bat_pct_pkg::ST_FRAC: begin
            // quotient of at most five, three restoring steps msb first
            fr_rem_in = fr_ge ? fr_rem_ff - shifted : fr_rem_ff;
            fr_q_in   = q_next;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               pct_in   = (pct_wide > bat_pct_pkg::FULL_PERCENT)
                          ? PCT_W'(bat_pct_pkg::FULL_PERCENT) : pct_wide[PCT_W-1:0];
               state_in = bat_pct_pkg::ST_OUT;
            end
         end
         bat_pct_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_avg_in   = avg_ff;
               rsp_mv_in    = mv_ff;
               rsp_pct_in   = pct_ff;
               rsp_valid_in = 1'b1;
               state_in     = bat_pct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bat_pct_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bat_pct_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
         slot_ff      <= '0;
         num_ff       <= bat_pct_pkg::NUM_RESET;
         den_ff       <= bat_pct_pkg::DEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         hist_ff      <= hist_in;
         slot_ff      <= slot_in;
         num_ff       <= num_in;
         den_ff       <= den_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      sum_ff     <= sum_in;
      cnt_ff     <= cnt_in;
      div_q_ff   <= div_q_in;
      div_r_ff   <= div_r_in;
      div_d_ff   <= div_d_in;
      mul_acc_ff <= mul_acc_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      avg_ff     <= avg_in;
      scaled_ff  <= scaled_in;
      prod_ff    <= prod_in;
      mv_ff      <= mv_in;
      pt_ff      <= pt_in;
      base_ff    <= base_in;
      fr_rem_ff  <= fr_rem_in;
      span_ff    <= span_in;
      fr_q_ff    <= fr_q_in;
      pct_ff     <= pct_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_mv_ff  <= rsp_mv_in;
      rsp_pct_ff <= rsp_pct_in;
   end

   `ASSERT_ALWAYS(a_slot_in_range, clock, reset, slot_ff <= SLOT_LAST)
   `ASSERT_IMPLIES(a_pct_bounded, clock, reset, rsp_valid_ff, rsp_pct_ff <= PCT_FULL)
   `ASSERT_IMPLIES(a_search_in_curve, clock, reset, in_search, int'(pt_ff) < CURVE_POINTS)
   `ASSERT_NEXT(a_accept_starts_sum, clock, reset, req_tvalid && req_tready, in_sum && !req_tready)

endmodule
